>>> sv/fcu_pkg.sv
// ----------------------------------------------------------------------------
// fcu_pkg
// Shared types, microprogram and helpers of the Fresnel coefficient unit.
// ----------------------------------------------------------------------------
package fcu_pkg;

  typedef logic signed [63:0] fx64_t;

  localparam fx64_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx64_t FX_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [5:0] PROG_END = 6'd32;

  typedef struct packed {
    logic tm;
    logic trans;
    logic bad_cos;
    logic perm_eq;
  } fcu_class_t;

  typedef enum logic [4:0] {
    R_ZERO, R_ONE, R_NI_RE, R_NI_IM, R_NT_RE, R_NT_IM, R_MUI, R_MUT,
    R_CI, R_CO_RE, R_CO_IM, R_P0, R_P1, R_Q0, R_Q1, R_R0,
    R_R1, R_L0, R_L1, R_H0, R_H1, R_G, R_N0, R_N1,
    R_E0, R_E1, R_C0, R_C1, R_I0, R_I1, R_S, R_INTEN
  } reg_sel_t;

  typedef enum logic [2:0] {
    M_SQ, M_RND, M_DIV, M_SQRT, M_SUMS, M_ISUM
  } mode_t;

  typedef enum logic [2:0] {
    C_ALL, C_RATIO, C_TM, C_TE, C_PERM, C_TM_PERM, C_TE_PERM, C_TRANS
  } cond_t;

  typedef struct packed {
    cond_t    cond;
    mode_t    mode;
    reg_sel_t a1;
    reg_sel_t a2;
    reg_sel_t b1;
    reg_sel_t b2;
    logic     b_neg;
    reg_sel_t dst;
  } uop_t;

  typedef enum logic [3:0] {
    B_IDLE, B_FETCH, B_MUL, B_FIN, B_DCHK, B_DIV, B_SQRT, B_WB, B_OUT
  } back_state_t;

  function automatic uop_t mk(cond_t c, mode_t m, reg_sel_t a1, reg_sel_t a2,
                              reg_sel_t b1, reg_sel_t b2, logic bn, reg_sel_t d);
    uop_t u;
    u.cond  = c;
    u.mode  = m;
    u.a1    = a1;
    u.a2    = a2;
    u.b1    = b1;
    u.b2    = b2;
    u.b_neg = bn;
    u.dst   = d;
    return u;
  endfunction

  // each step: dst = f(a1*a2 +/- b1*b2)
  function automatic uop_t prog(logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = mk(C_RATIO, M_RND, R_NT_RE, R_CO_RE, R_NT_IM, R_CO_IM, 1'b1, R_P0);
      5'd1:  u = mk(C_RATIO, M_RND, R_NT_RE, R_CO_IM, R_NT_IM, R_CO_RE, 1'b0, R_P1);
      5'd2:  u = mk(C_RATIO, M_RND, R_NI_RE, R_CI, R_ZERO, R_ZERO, 1'b0, R_Q0);
      5'd3:  u = mk(C_RATIO, M_RND, R_NI_IM, R_CI, R_ZERO, R_ZERO, 1'b0, R_Q1);
      5'd4:  u = mk(C_RATIO, M_SQ, R_Q0, R_Q0, R_Q1, R_Q1, 1'b0, R_ZERO);
      5'd5:  u = mk(C_RATIO, M_DIV, R_P0, R_Q0, R_P1, R_Q1, 1'b0, R_R0);
      5'd6:  u = mk(C_RATIO, M_DIV, R_P1, R_Q0, R_P0, R_Q1, 1'b1, R_R1);
      5'd7:  u = mk(C_TM, M_SQ, R_NI_RE, R_NI_RE, R_NI_IM, R_NI_IM, 1'b0, R_ZERO);
      5'd8:  u = mk(C_TM, M_DIV, R_NT_RE, R_NI_RE, R_NT_IM, R_NI_IM, 1'b0, R_L0);
      5'd9:  u = mk(C_TM, M_DIV, R_NT_IM, R_NI_RE, R_NT_RE, R_NI_IM, 1'b1, R_L1);
      5'd10: u = mk(C_TM, M_SQ, R_CI, R_CI, R_ZERO, R_ZERO, 1'b0, R_ZERO);
      5'd11: u = mk(C_TM, M_DIV, R_CO_RE, R_CI, R_ZERO, R_ZERO, 1'b0, R_H0);
      5'd12: u = mk(C_TM, M_DIV, R_CO_IM, R_CI, R_ZERO, R_ZERO, 1'b0, R_H1);
      5'd13: u = mk(C_TE, M_RND, R_ONE, R_ONE, R_ZERO, R_ZERO, 1'b0, R_L0);
      5'd14: u = mk(C_TE, M_RND, R_ZERO, R_ZERO, R_ZERO, R_ZERO, 1'b0, R_L1);
      5'd15: u = mk(C_TE, M_RND, R_R0, R_ONE, R_ZERO, R_ZERO, 1'b0, R_H0);
      5'd16: u = mk(C_TE, M_RND, R_R1, R_ONE, R_ZERO, R_ZERO, 1'b0, R_H1);
      5'd17: u = mk(C_PERM, M_SQ, R_MUT, R_MUT, R_ZERO, R_ZERO, 1'b0, R_ZERO);
      5'd18: u = mk(C_PERM, M_DIV, R_MUI, R_MUT, R_ZERO, R_ZERO, 1'b0, R_G);
      5'd19: u = mk(C_TM_PERM, M_RND, R_L0, R_G, R_ZERO, R_ZERO, 1'b0, R_L0);
      5'd20: u = mk(C_TM_PERM, M_RND, R_L1, R_G, R_ZERO, R_ZERO, 1'b0, R_L1);
      5'd21: u = mk(C_TE_PERM, M_RND, R_H0, R_G, R_ZERO, R_ZERO, 1'b0, R_H0);
      5'd22: u = mk(C_TE_PERM, M_RND, R_H1, R_G, R_ZERO, R_ZERO, 1'b0, R_H1);
      5'd23: u = mk(C_ALL, M_SUMS, R_ZERO, R_ZERO, R_ZERO, R_ZERO, 1'b0, R_ZERO);
      5'd24: u = mk(C_ALL, M_SQ, R_E0, R_E0, R_E1, R_E1, 1'b0, R_ZERO);
      5'd25: u = mk(C_ALL, M_DIV, R_N0, R_E0, R_N1, R_E1, 1'b0, R_C0);
      5'd26: u = mk(C_ALL, M_DIV, R_N1, R_E0, R_N0, R_E1, 1'b1, R_C1);
      5'd27: u = mk(C_ALL, M_RND, R_C0, R_C0, R_ZERO, R_ZERO, 1'b0, R_I0);
      5'd28: u = mk(C_ALL, M_RND, R_C1, R_C1, R_ZERO, R_ZERO, 1'b0, R_I1);
      5'd29: u = mk(C_ALL, M_ISUM, R_ZERO, R_ZERO, R_ZERO, R_ZERO, 1'b0, R_INTEN);
      5'd30: u = mk(C_TRANS, M_SQRT, R_R0, R_R0, R_R1, R_R1, 1'b0, R_S);
      5'd31: u = mk(C_TRANS, M_RND, R_S, R_INTEN, R_ZERO, R_ZERO, 1'b0, R_INTEN);
      default: u = mk(C_ALL, M_SUMS, R_ZERO, R_ZERO, R_ZERO, R_ZERO, 1'b0, R_ZERO);
    endcase
    return u;
  endfunction

  function automatic logic cond_ok(cond_t c, fcu_class_t k);
    logic r;
    case (c)
      C_ALL:     r = 1'b1;
      C_RATIO:   r = !k.tm || k.trans;
      C_TM:      r = k.tm;
      C_TE:      r = !k.tm;
      C_PERM:    r = !k.perm_eq;
      C_TM_PERM: r = k.tm && !k.perm_eq;
      C_TE_PERM: r = !k.tm && !k.perm_eq;
      C_TRANS:   r = k.trans;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic fx64_t sat_add64(fx64_t a, fx64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

  function automatic fx64_t sat_sub64(fx64_t a, fx64_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

endpackage

>>> sv/fresnel_coefficient_unit_top.sv
// ----------------------------------------------------------------------------
// fresnel_coefficient_unit_top: complex Fresnel coefficient and intensity
// per queued ray, computed by a microprogram on the shared 32x32 MAC, the
// bit-serial divider and the bit-serial square root; a zero divisor ends the
// program early and an invalid incident cosine skips it. The engine takes one
// item at a time and finishes it before the next; a two-entry queue takes
// commands ahead. Synchronous reset empties the queue, idles the engine and
// drops done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module fresnel_coefficient_unit_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             cmd,
  input  logic signed [DATA_WIDTH-1:0] index_in_re,
  input  logic signed [DATA_WIDTH-1:0] index_in_im,
  input  logic signed [DATA_WIDTH-1:0] index_out_re,
  input  logic signed [DATA_WIDTH-1:0] index_out_im,
  input  logic signed [DATA_WIDTH-1:0] perm_in,
  input  logic signed [DATA_WIDTH-1:0] perm_out,
  input  logic signed [DATA_WIDTH-1:0] cos_incident,
  input  logic signed [DATA_WIDTH-1:0] cos_out_re,
  input  logic signed [DATA_WIDTH-1:0] cos_out_im,
  output logic                   done,
  output logic signed [DATA_WIDTH-1:0] coef_re,
  output logic signed [DATA_WIDTH-1:0] coef_im,
  output logic signed [DATA_WIDTH-1:0] intensity,
  output logic                   error
);
  import fcu_pkg::*;

  localparam int QDEPTH = 2;
  localparam int CLW    = $bits(fcu_class_t);
  localparam int QWID   = CLW + 9 * DATA_WIDTH;

  fcu_class_t       cls_in, cls_out;
  logic             q_push, q_pop, q_valid, q_full;
  logic [QWID-1:0]  q_wdata, q_rdata;

  fcu_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cos_incident (cos_incident),
    .perm_in      (perm_in),
    .perm_out     (perm_out),
    .q_full       (q_full),
    .push         (q_push),
    .cls          (cls_in)
  );

  assign q_wdata = {cls_in, index_in_re, index_in_im, index_out_re, index_out_im,
                    perm_in, perm_out, cos_incident, cos_out_re, cos_out_im};

  fcu_queue #(.WIDTH(QWID), .DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (q_full)
  );

  assign cls_out = q_rdata[QWID-1 -: CLW];

  fcu_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_class   (cls_out),
    .q_data    (q_rdata[9*DATA_WIDTH-1:0]),
    .q_pop     (q_pop),
    .done      (done),
    .coef_re   (coef_re),
    .coef_im   (coef_im),
    .intensity (intensity),
    .error     (error)
  );

`ifndef NO_ASSERTIONS
  // one result per transfer cycle, never two in a row
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");

  // rejected items carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (coef_re == '0 && coef_im == '0 && intensity == '0))
    else $error("rejected item with nonzero payload");

  // engine only pops a queue that holds an item
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> sv/fcu_front.sv
// ----------------------------------------------------------------------------
// fcu_front
// Takes commands, checks the incident cosine and permeabilities, queues items.
// ----------------------------------------------------------------------------
module fcu_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             cmd,
  input  logic signed [DATA_WIDTH-1:0] cos_incident,
  input  logic signed [DATA_WIDTH-1:0] perm_in,
  input  logic signed [DATA_WIDTH-1:0] perm_out,
  input  logic                   q_full,
  output logic                   push,
  output fcu_pkg::fcu_class_t    cls
);
  import fcu_pkg::*;

  fx64_t ci64;
  fx64_t one64;

  assign ci64  = 64'(cos_incident);
  assign one64 = 64'(64'sd1 <<< FRAC_BITS);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    cls.tm      = cmd[0];
    cls.trans   = cmd[1];
    cls.bad_cos = (ci64 <= 64'sd0) || (ci64 > one64);
    cls.perm_eq = (perm_in == perm_out);
  end

endmodule

>>> sv/fcu_queue.sv
// ----------------------------------------------------------------------------
// fcu_queue
// Small FIFO between the command front and the arithmetic back.
// ----------------------------------------------------------------------------
module fcu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid,
  output logic             full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;

  assign rdata = mem[rp];
  assign valid = (cnt != '0);
  assign full  = (cnt == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

>>> sv/fcu_back.sv
// ----------------------------------------------------------------------------
// fcu_back
// Microprogrammed engine: shared 32x32 multiply-accumulate, bit-serial
// divider and square root over 64-bit fixed-point work registers.
// ----------------------------------------------------------------------------
module fcu_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  fcu_pkg::fcu_class_t    q_class,
  input  logic [9*DATA_WIDTH-1:0] q_data,
  output logic                   q_pop,
  output logic                   done,
  output logic signed [DATA_WIDTH-1:0] coef_re,
  output logic signed [DATA_WIDTH-1:0] coef_im,
  output logic signed [DATA_WIDTH-1:0] intensity,
  output logic                   error
);
  import fcu_pkg::*;

  localparam int MW  = 129;                 // |a*b + c*d| for 64-bit operands
  localparam int AW  = MW + 1;
  localparam int NW  = MW + FRAC_BITS + 2;  // scaled dividend
  localparam int QW  = 63;
  localparam int DVW = MW + 1;
  localparam int HW  = NW - QW;
  localparam int CW  = (HW > DVW) ? HW : DVW;
  localparam logic [3:0] MUL_LAST = 4'd8;
  localparam fx64_t ONE = 64'(64'sd1 <<< FRAC_BITS);
  localparam fx64_t TWO = 64'(64'sd1 <<< (FRAC_BITS + 1));
  localparam fx64_t DMAX = 64'((65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1);
  localparam fx64_t DMIN = -DMAX - 64'sd1;

  back_state_t state, state_next;
  logic [5:0]  pc;
  uop_t        op;
  fcu_class_t  cls;
  logic        bad;
  logic        run_op;

  fx64_t ni_re, ni_im, nt_re, nt_im, mui, mut, ci, co_re, co_im;
  fx64_t p0, p1, q0, q1, r0, r1, l0, l1, h0, h1, g;
  fx64_t n0, n1, e0, e1, c0, c1, i0, i1, s, inten;
  logic [MW-1:0] dsq;

  logic [63:0] ma1, ma2, mb1, mb2;
  logic        neg_a, neg_b;
  logic [3:0]  mcnt;
  logic [63:0] pp;
  logic [1:0]  pp_sh;
  logic        pp_neg;
  logic signed [AW-1:0] acc;

  logic [NW-1:0]  divn;
  logic [DVW-1:0] rem;
  logic [QW-1:0]  nlow, quo;
  logic           div_neg, div_ovf;
  logic [5:0]     icnt;
  logic [127:0]   sv;
  logic [65:0]    srem;
  logic [63:0]    root;

  logic        wr_en;
  reg_sel_t    wr_sel;
  fx64_t       wr_val;
  logic        sums_en;

  fx64_t       va1, va2, vb1, vb2;

  assign op     = prog(pc[4:0]);
  assign run_op = cond_ok(op.cond, cls);

  function automatic logic signed [DATA_WIDTH-1:0] fld(int k);
    return q_data[(8 - k)*DATA_WIDTH +: DATA_WIDTH];
  endfunction

  function automatic logic [63:0] mag64(fx64_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_out(fx64_t v);
    fx64_t t;
    t = (v > DMAX) ? DMAX : ((v < DMIN) ? DMIN : v);
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic fx64_t rd(reg_sel_t k);
    fx64_t v;
    case (k)
      R_ZERO:  v = '0;
      R_ONE:   v = ONE;
      R_NI_RE: v = ni_re;
      R_NI_IM: v = ni_im;
      R_NT_RE: v = nt_re;
      R_NT_IM: v = nt_im;
      R_MUI:   v = mui;
      R_MUT:   v = mut;
      R_CI:    v = ci;
      R_CO_RE: v = co_re;
      R_CO_IM: v = co_im;
      R_P0:    v = p0;
      R_P1:    v = p1;
      R_Q0:    v = q0;
      R_Q1:    v = q1;
      R_R0:    v = r0;
      R_R1:    v = r1;
      R_L0:    v = l0;
      R_L1:    v = l1;
      R_H0:    v = h0;
      R_H1:    v = h1;
      R_G:     v = g;
      R_N0:    v = n0;
      R_N1:    v = n1;
      R_E0:    v = e0;
      R_E1:    v = e1;
      R_C0:    v = c0;
      R_C1:    v = c1;
      R_I0:    v = i0;
      R_I1:    v = i1;
      R_S:     v = s;
      R_INTEN: v = inten;
      default: v = '0;
    endcase
    return v;
  endfunction

  // operands of the current step
  always_comb begin
    va1 = rd(op.a1);
    va2 = rd(op.a2);
    vb1 = rd(op.b1);
    vb2 = rd(op.b2);
  end

  // accumulator magnitude and rounding
  logic [AW-1:0] acc_abs;
  logic [MW-1:0] mag;
  logic          acc_neg;
  logic [MW:0]   rs;
  logic [63:0]   rq;
  fx64_t         rnd_val;

  assign acc_neg = acc[AW-1];
  assign acc_abs = acc_neg ? AW'(-acc) : AW'(acc);
  assign mag     = acc_abs[MW-1:0];
  assign rs      = ({1'b0, mag} + ((MW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rq      = {1'b0, rs[62:0]};

  always_comb begin
    if (|rs[MW:63]) rnd_val = acc_neg ? FX_MIN : FX_MAX;
    else rnd_val = acc_neg ? fx64_t'(64'd0 - rq) : fx64_t'(rq);
  end

  // divider
  logic [DVW-1:0] dv;
  logic [HW-1:0]  div_hi;
  logic           hi_ge;
  logic [DVW:0]   dt;
  logic           dge;
  logic [63:0]    qq;
  fx64_t          wb_val;

  assign dv     = {dsq, 1'b0};
  assign div_hi = divn[NW-1:QW];
  assign hi_ge  = CW'(div_hi) >= CW'(dv);
  assign dt     = {rem, nlow[QW-1]};
  assign dge    = dt >= {1'b0, dv};
  assign qq     = {1'b0, quo};

  // square root
  logic [67:0] st, strial;
  logic        sge;

  assign st     = {srem, sv[127:126]};
  assign strial = {2'b00, root, 2'b01};
  assign sge    = st >= strial;

  always_comb begin
    if (op.mode == M_SQRT) wb_val = root[63] ? FX_MAX : fx64_t'(root);
    else if (div_ovf) wb_val = div_neg ? FX_MIN : FX_MAX;
    else wb_val = div_neg ? fx64_t'(64'd0 - qq) : fx64_t'(qq);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (q_valid) state_next = q_class.bad_cos ? B_OUT : B_FETCH;
      B_FETCH: begin
        if (pc == PROG_END) state_next = B_OUT;
        else if (run_op) begin
          state_next = (op.mode == M_SUMS || op.mode == M_ISUM) ? B_FIN : B_MUL;
        end
      end
      B_MUL:   if (mcnt == MUL_LAST) state_next = B_FIN;
      B_FIN: begin
        case (op.mode)
          M_SQ:    state_next = (mag == '0) ? B_OUT : B_FETCH;
          M_DIV:   state_next = B_DCHK;
          M_SQRT:  state_next = B_SQRT;
          default: state_next = B_FETCH;
        endcase
      end
      B_DCHK:  state_next = hi_ge ? B_WB : B_DIV;
      B_DIV:   if (icnt == 6'(QW - 1)) state_next = B_WB;
      B_SQRT:  if (icnt == 6'd63) state_next = B_WB;
      B_WB:    state_next = B_FETCH;
      B_OUT:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop   = (state == B_IDLE) && q_valid;
    wr_en   = 1'b0;
    wr_sel  = op.dst;
    wr_val  = rnd_val;
    sums_en = 1'b0;
    case (state)
      B_FIN: begin
        case (op.mode)
          M_RND:  wr_en = 1'b1;
          M_ISUM: begin
            wr_en  = 1'b1;
            wr_val = sat_add64(i0, i1);
          end
          M_SUMS: sums_en = 1'b1;
          default: ;
        endcase
      end
      B_WB: begin
        wr_en  = 1'b1;
        wr_val = wb_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      pc    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == B_OUT);
      case (state)
        B_IDLE:  pc <= '0;
        B_FETCH: if (pc != PROG_END && !run_op) pc <= pc + 1'b1;
        B_FIN:   if (op.mode != M_DIV && op.mode != M_SQRT) pc <= pc + 1'b1;
        B_WB:    pc <= pc + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cls   <= q_class;
      bad   <= q_class.bad_cos;
      ni_re <= 64'(fld(0));
      ni_im <= 64'(fld(1));
      nt_re <= 64'(fld(2));
      nt_im <= 64'(fld(3));
      mui   <= 64'(fld(4));
      mut   <= 64'(fld(5));
      ci    <= 64'(fld(6));
      co_re <= 64'(fld(7));
      co_im <= 64'(fld(8));
    end

    if (state == B_FETCH) begin
      ma1   <= mag64(va1);
      ma2   <= mag64(va2);
      mb1   <= mag64(vb1);
      mb2   <= mag64(vb2);
      neg_a <= va1[63] ^ va2[63];
      neg_b <= vb1[63] ^ vb2[63] ^ op.b_neg;
      acc   <= '0;
      mcnt  <= '0;
    end

    if (state == B_MUL) begin
      mcnt <= mcnt + 1'b1;
      if (mcnt != MUL_LAST) begin
        pp <= 64'((mcnt[0] ? (mcnt[2] ? mb1[63:32] : ma1[63:32])
                           : (mcnt[2] ? mb1[31:0]  : ma1[31:0])) *
                  (mcnt[1] ? (mcnt[2] ? mb2[63:32] : ma2[63:32])
                           : (mcnt[2] ? mb2[31:0]  : ma2[31:0])));
        pp_sh  <= 2'(mcnt[0]) + 2'(mcnt[1]);
        pp_neg <= mcnt[2] ? neg_b : neg_a;
      end
      // accumulate the previous partial product
      if (mcnt != '0) begin
        if (pp_neg) acc <= acc - AW'(AW'(pp) << (7'd32 * 7'(pp_sh)));
        else acc <= acc + AW'(AW'(pp) << (7'd32 * 7'(pp_sh)));
      end
    end

    if (state == B_FIN) begin
      if (op.mode == M_SQ) begin
        dsq <= mag;
        if (mag == '0) bad <= 1'b1;
      end
      divn    <= (NW'(mag) << (FRAC_BITS + 1)) + NW'(dsq);
      div_neg <= acc_neg;
      sv      <= mag[127:0];
      srem    <= '0;
      root    <= '0;
      icnt    <= '0;
    end

    if (state == B_DCHK) begin
      div_ovf <= hi_ge;
      rem     <= DVW'(div_hi);
      nlow    <= divn[QW-1:0];
      quo     <= '0;
    end

    if (state == B_DIV) begin
      rem  <= dge ? DVW'(dt - {1'b0, dv}) : DVW'(dt);
      nlow <= {nlow[QW-2:0], 1'b0};
      quo  <= {quo[QW-2:0], dge};
      icnt <= icnt + 1'b1;
    end

    if (state == B_SQRT) begin
      srem <= sge ? 66'(st - strial) : 66'(st);
      root <= {root[62:0], sge};
      sv   <= {sv[125:0], 2'b00};
      icnt <= icnt + 1'b1;
    end

    if (sums_en) begin
      e0 <= sat_add64(l0, h0);
      e1 <= sat_add64(l1, h1);
      n0 <= cls.trans ? TWO : sat_sub64(l0, h0);
      n1 <= cls.trans ? fx64_t'(64'sd0) : sat_sub64(l1, h1);
    end

    if (wr_en) begin
      case (wr_sel)
        R_P0:    p0    <= wr_val;
        R_P1:    p1    <= wr_val;
        R_Q0:    q0    <= wr_val;
        R_Q1:    q1    <= wr_val;
        R_R0:    r0    <= wr_val;
        R_R1:    r1    <= wr_val;
        R_L0:    l0    <= wr_val;
        R_L1:    l1    <= wr_val;
        R_H0:    h0    <= wr_val;
        R_H1:    h1    <= wr_val;
        R_G:     g     <= wr_val;
        R_C0:    c0    <= wr_val;
        R_C1:    c1    <= wr_val;
        R_I0:    i0    <= wr_val;
        R_I1:    i1    <= wr_val;
        R_S:     s     <= wr_val;
        R_INTEN: inten <= wr_val;
        default: ;
      endcase
    end

    if (state == B_OUT) begin
      error     <= bad;
      coef_re   <= bad ? '0 : sat_out(c0);
      coef_im   <= bad ? '0 : sat_out(c1);
      intensity <= bad ? '0 : sat_out(inten);
    end
  end

endmodule
